@@ sv/ppmd_pkg.sv @@
package ppmd_pkg;

   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_THREE   = 8'h33;

   localparam logic [15:0] VAL_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_image;
   } ppmd_req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last_pixel;
      logic        ascii_format;
      logic [15:0] max_sample;
   } ppmd_rsp_type;

   typedef struct packed {
      logic         valid;
      ppmd_rsp_type word;
   } ppmd_result_type;

endpackage

@@ sv/ppmd_if.sv @@
interface ppmd_req_if;
   import ppmd_pkg::*;

   logic         valid;
   logic         ready;
   ppmd_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppmd_rsp_if;
   import ppmd_pkg::*;

   logic         valid;
   logic         ready;
   ppmd_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/ppmd_parser.sv @@
module ppmd_parser #(
   parameter int DIM_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  ppmd_pkg::ppmd_req_type    in_word,
   output ppmd_pkg::ppmd_result_type result
);
   import ppmd_pkg::*;

   localparam int PixW = 2 * DIM_BITS;
   localparam logic [15:0] DimMax = 16'((32'd1 << DIM_BITS) - 32'd1);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_DIM1,
      PH_DIM2,
      PH_MAXV,
      PH_ASCII,
      PH_BINARY,
      PH_DONE
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [15:0]         tok_val_ff, tok_val_in;
   logic                started_ff, started_in;
   logic                digits_end_ff, digits_end_in;
   logic                comment_ff, comment_in;
   logic [1:0]          char_idx_ff, char_idx_in;
   logic                ascii_ff, ascii_in;
   logic [DIM_BITS-1:0] dim1_ff, dim1_in;
   logic [DIM_BITS-1:0] dim2_ff, dim2_in;
   logic [15:0]         max_ff, max_in;
   logic [PixW-1:0]     pixels_ff, pixels_in;
   logic [1:0]          sidx_ff, sidx_in;
   logic [15:0]         red_ff, red_in;
   logic [15:0]         green_ff, green_in;

   logic                samp_go;
   logic [15:0]         samp_val;
   logic [19:0]         acc_sum;
   logic [DIM_BITS-1:0] dim_sat;
   logic [7:0]          cur_byte;
   logic                is_sep;
   logic                is_digit;

   assign cur_byte = in_word.data_byte;
   assign is_sep   = (cur_byte == CHAR_SPACE) || (cur_byte == CHAR_NEWLINE);
   assign is_digit = (cur_byte >= CHAR_ZERO) && (cur_byte <= CHAR_NINE);

   always_comb begin
      phase_in      = phase_ff;
      tok_val_in    = tok_val_ff;
      started_in    = started_ff;
      digits_end_in = digits_end_ff;
      comment_in    = comment_ff;
      char_idx_in   = char_idx_ff;
      ascii_in      = ascii_ff;
      dim1_in       = dim1_ff;
      dim2_in       = dim2_ff;
      max_in        = max_ff;
      pixels_in     = pixels_ff;
      sidx_in       = sidx_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      samp_go       = 1'b0;
      samp_val      = '0;
      acc_sum       = '0;
      dim_sat       = '0;
      result        = '0;

      if (step_en) begin
         if (in_word.start_of_image) begin
            phase_in      = PH_MAGIC;
            tok_val_in    = '0;
            started_in    = 1'b0;
            digits_end_in = 1'b0;
            comment_in    = 1'b0;
            char_idx_in   = '0;
            ascii_in      = 1'b0;
            dim1_in       = '0;
            dim2_in       = '0;
            max_in        = '0;
            pixels_in     = '0;
            sidx_in       = '0;
            red_in        = '0;
            green_in      = '0;
         end

         dim_sat = (tok_val_in > DimMax) ? DIM_BITS'(DimMax) : DIM_BITS'(tok_val_in);
         acc_sum = 20'(tok_val_in) * 20'd10 + 20'(8'(cur_byte - CHAR_ZERO));

         priority if (phase_in == PH_DONE) begin
            samp_go = 1'b0;
         end else if (phase_in == PH_BINARY) begin
            samp_go  = 1'b1;
            samp_val = 16'(cur_byte);
         end else if (comment_in) begin
            if (cur_byte == CHAR_NEWLINE) begin
               comment_in = 1'b0;
            end
         end else if (is_sep) begin
            if (started_in) begin
               unique case (phase_in)
                  PH_MAGIC: begin
                     phase_in = PH_DIM1;
                  end
                  PH_DIM1: begin
                     dim1_in  = dim_sat;
                     phase_in = PH_DIM2;
                  end
                  PH_DIM2: begin
                     dim2_in  = dim_sat;
                     phase_in = PH_MAXV;
                  end
                  PH_MAXV: begin
                     max_in    = tok_val_in;
                     pixels_in = PixW'(dim1_in) * PixW'(dim2_in);
                     sidx_in   = '0;
                     priority if (dim1_in == '0 || dim2_in == '0) begin
                        phase_in = PH_DONE;
                     end else if (ascii_in) begin
                        phase_in = PH_ASCII;
                     end else begin
                        phase_in = PH_BINARY;
                     end
                  end
                  PH_ASCII: begin
                     samp_go  = 1'b1;
                     samp_val = tok_val_in;
                  end
                  default: begin
                     samp_go = 1'b0;
                  end
               endcase
               tok_val_in    = '0;
               started_in    = 1'b0;
               digits_end_in = 1'b0;
               char_idx_in   = '0;
            end
         end else if (!started_in && cur_byte == CHAR_HASH) begin
            comment_in = 1'b1;
         end else begin
            started_in = 1'b1;
            if (phase_in == PH_MAGIC && char_idx_in == 2'd1) begin
               ascii_in = (cur_byte == CHAR_THREE);
            end
            if (char_idx_in != 2'd3) begin
               char_idx_in = char_idx_in + 2'd1;
            end
            if (!digits_end_in && is_digit) begin
               tok_val_in = (acc_sum > 20'(VAL_MAX)) ? VAL_MAX : acc_sum[15:0];
            end else begin
               digits_end_in = 1'b1;
            end
         end

         if (samp_go) begin
            unique case (sidx_in)
               2'd0: begin
                  red_in  = samp_val;
                  sidx_in = 2'd1;
               end
               2'd1: begin
                  green_in = samp_val;
                  sidx_in  = 2'd2;
               end
               default: begin
                  sidx_in                  = '0;
                  pixels_in                = pixels_in - PixW'(1);
                  result.valid             = 1'b1;
                  result.word.red          = red_in;
                  result.word.green        = green_in;
                  result.word.blue         = samp_val;
                  result.word.last_pixel   = (pixels_in == '0);
                  result.word.ascii_format = ascii_in;
                  result.word.max_sample   = max_in;
                  if (pixels_in == '0) begin
                     phase_in = PH_DONE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         tok_val_ff    <= '0;
         started_ff    <= 1'b0;
         digits_end_ff <= 1'b0;
         comment_ff    <= 1'b0;
         char_idx_ff   <= '0;
         ascii_ff      <= 1'b0;
         dim1_ff       <= '0;
         dim2_ff       <= '0;
         max_ff        <= '0;
         pixels_ff     <= '0;
         sidx_ff       <= '0;
         red_ff        <= '0;
         green_ff      <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         tok_val_ff    <= tok_val_in;
         started_ff    <= started_in;
         digits_end_ff <= digits_end_in;
         comment_ff    <= comment_in;
         char_idx_ff   <= char_idx_in;
         ascii_ff      <= ascii_in;
         dim1_ff       <= dim1_in;
         dim2_ff       <= dim2_in;
         max_ff        <= max_in;
         pixels_ff     <= pixels_in;
         sidx_ff       <= sidx_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
      end
   end

endmodule

@@ sv/ppm_stream_decoder.sv @@
// Streaming PPM parser (P3 text and P6 binary): takes one file byte per word on req_chan and
// returns one word on rsp_chan per completed pixel, carrying the three samples, a last-pixel
// flag, the text/binary format flag and the header's maximum value. One byte is accepted
// every cycle while rsp_chan keeps up; a byte is first registered on input, then parsed when
// the output register is free, and its pixel is registered at the same edge as that parse, so
// rsp valid is driven from the output register. The parser state is updated
// once per byte in a single pass. A byte with start_of_image set restarts the header parse.
// Text samples are delivered only once the separator after them arrives. DIM_BITS sets the
// width of each image dimension; larger values saturate, and the pixel counter holds
// 2*DIM_BITS bits.
module ppm_stream_decoder #(
   parameter int DIM_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ppmd_req_if.sink   req_chan,
   ppmd_rsp_if.source rsp_chan
);
   import ppmd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   ppmd_req_type    in_word_ff, in_word_in;
   logic            out_valid_ff, out_valid_in;
   ppmd_rsp_type    out_word_ff, out_word_in;
   logic            out_free;
   logic            step_en;
   ppmd_result_type result;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   ppmd_parser #(
      .DIM_BITS (DIM_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .in_word (in_word_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_word_in  = req_chan.data;
      end
      if (out_free) begin
         out_valid_in = step_en && result.valid;
         out_word_in  = result.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

endmodule

@@ sv/ppmd_checker.sv @@
module ppmd_protocol_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ppmd_pkg::ppmd_rsp_type rsp_word
);
   import ppmd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp word without a req word two cycles earlier");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled while rsp side free");

endmodule

bind ppm_stream_decoder ppmd_protocol_checker u_ppmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.data)
);
